>>> rtl/ggvl_pkg.sv
// ----------------------------------------------------------------------------
// ggvl_pkg
// Shared sizes, codes and controller/datapath interface types for the greedy
// graph vertex labeler.
// ----------------------------------------------------------------------------
package ggvl_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int EFF_W        = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W        = 7;
    localparam int LABEL_W      = 2;
    localparam int REQ_W        = 3;

    typedef logic [VIDX_W-1:0]       vidx_t;
    typedef logic [MAX_VERTICES-1:0] row_t;
    typedef logic [LABEL_W-1:0]      label_t;
    typedef logic [REQ_W-1:0]        req_code_t;

    // request codes
    localparam req_code_t REQ_ADD_EDGE   = 3'd0;
    localparam req_code_t REQ_VISIT      = 3'd1;
    localparam req_code_t REQ_READ       = 3'd2;
    localparam req_code_t REQ_CLR_LABELS = 3'd3;
    localparam req_code_t REQ_CLR_GRAPH  = 3'd4;

    // label values
    localparam label_t LBL_CENTRE  = 2'd0; // visited, had unlabeled neighbours
    localparam label_t LBL_SETTLED = 2'd1; // all neighbours already labeled
    localparam label_t LBL_PLAIN   = 2'd2; // isolated vertex or later neighbour
    localparam label_t LBL_FIRST   = 2'd3; // lowest-numbered neighbour

    // register map
    localparam int REG_VERTEX_COUNT = 0;

    typedef struct packed {
        logic load;       // capture the accepted request
        logic row_rd;     // read adjacency row
        logic row_wr;     // write adjacency row
        logic row_sel_b;  // row address is vertex_b, else vertex_a
        logic clr_mask;   // clear labeled mask
        logic clr_rows;   // clear adjacency row valid bits
        logic vis_mark;   // label the visited vertex, capture neighbours
        logic scan_step;  // label one neighbour slot and advance
        logic lab_rd;     // read label of vertex_a
        logic out_load;   // load the result register
    } ggvl_cmd_t;

    typedef struct packed {
        logic add_ok;
        logic visit_go;
        logic clr_lab;
        logic clr_graph;
        logic nb_pending;  // visited vertex has unlabeled neighbours
        logic scan_last;
        logic out_free;
    } ggvl_status_t;

endpackage

>>> rtl/ggvl_dpath.sv
// ----------------------------------------------------------------------------
// ggvl_dpath
// Datapath: adjacency row memory with per-row valid bits, label memory,
// labeled mask, neighbour scan counter and the result register.
// ----------------------------------------------------------------------------
module ggvl_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ggvl_pkg::ggvl_cmd_t         cmd,
    output ggvl_pkg::ggvl_status_t      st,
    input  ggvl_pkg::req_code_t         s_req,
    input  ggvl_pkg::vidx_t             s_a,
    input  ggvl_pkg::vidx_t             s_b,
    input  logic [ggvl_pkg::CNT_W-1:0]  vertex_count,
    output logic                        m_tvalid,
    output logic [7:0]                  m_tdata,
    input  logic                        m_tready
);

    ggvl_pkg::req_code_t              req_reg;
    ggvl_pkg::vidx_t                  a_reg;
    ggvl_pkg::vidx_t                  b_reg;

    ggvl_pkg::row_t                   row_mem [ggvl_pkg::MAX_VERTICES];
    ggvl_pkg::row_t                   row_vld_reg;
    ggvl_pkg::row_t                   row_q_reg;
    logic                             row_q_vld_reg;

    ggvl_pkg::label_t                 lab_mem [ggvl_pkg::MAX_VERTICES];
    ggvl_pkg::label_t                 lab_q_reg;
    ggvl_pkg::row_t                   mask_reg;

    ggvl_pkg::row_t                   nb_reg;
    ggvl_pkg::vidx_t                  idx_reg;
    logic                             first_reg;

    logic                             out_vld_reg;
    logic [7:0]                       out_data_reg;

    logic [ggvl_pkg::EFF_W-1:0]       cnt_eff;
    ggvl_pkg::row_t                   active;
    logic                             a_ok, b_ok;
    logic                             is_add, is_visit, is_read;
    logic                             bad, show;
    ggvl_pkg::vidx_t                  row_addr, row_other;
    ggvl_pkg::row_t                   row_base, row_wdata;
    ggvl_pkg::row_t                   nb;
    logic                             nb_any, nb_unl;
    ggvl_pkg::label_t                 vis_label;
    logic                             lab_we;
    ggvl_pkg::vidx_t                  lab_waddr;
    ggvl_pkg::label_t                 lab_wdata;
    ggvl_pkg::label_t                 out_label;
    logic                             out_is_lab;

    // count in effect, capped at the matrix size
    always_comb begin
        if (int'(vertex_count) >= ggvl_pkg::MAX_VERTICES) begin
            cnt_eff = ggvl_pkg::EFF_W'(ggvl_pkg::MAX_VERTICES);
        end else begin
            cnt_eff = ggvl_pkg::EFF_W'(vertex_count);
        end
    end

    always_comb begin
        for (int i = 0; i < ggvl_pkg::MAX_VERTICES; i++) begin
            active[i] = (i < int'(cnt_eff));
        end
    end

    assign a_ok     = (ggvl_pkg::EFF_W'(a_reg) < cnt_eff);
    assign b_ok     = (ggvl_pkg::EFF_W'(b_reg) < cnt_eff);
    assign is_add   = (req_reg == ggvl_pkg::REQ_ADD_EDGE);
    assign is_visit = (req_reg == ggvl_pkg::REQ_VISIT);
    assign is_read  = (req_reg == ggvl_pkg::REQ_READ);
    assign bad      = (is_add && !(a_ok && b_ok)) || ((is_visit || is_read) && !a_ok);
    assign show     = a_ok && !bad;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req;
            a_reg   <= s_a;
            b_reg   <= s_b;
        end
    end

    // adjacency rows: one read and one write port, registered read
    assign row_addr  = cmd.row_sel_b ? b_reg : a_reg;
    assign row_other = cmd.row_sel_b ? a_reg : b_reg;
    assign row_base  = row_q_vld_reg ? row_q_reg : '0;
    assign row_wdata = row_base | (ggvl_pkg::row_t'(1) << row_other);

    always_ff @(posedge aclk) begin
        if (cmd.row_wr) begin
            row_mem[row_addr] <= row_wdata;
        end
        if (cmd.row_rd) begin
            row_q_reg     <= row_mem[row_addr];
            row_q_vld_reg <= row_vld_reg[row_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (cmd.clr_rows) begin
            row_vld_reg <= '0;
        end else if (cmd.row_wr) begin
            row_vld_reg[row_addr] <= 1'b1;
        end
    end

    // neighbours of the visited vertex
    assign nb     = row_base & active;
    assign nb_any = |nb;
    assign nb_unl = |(nb & ~mask_reg);

    always_comb begin
        if (!nb_any) begin
            vis_label = ggvl_pkg::LBL_PLAIN;
        end else if (!nb_unl) begin
            vis_label = ggvl_pkg::LBL_SETTLED;
        end else begin
            vis_label = ggvl_pkg::LBL_CENTRE;
        end
    end

    // labels: the mask doubles as valid bits, so an unmarked entry reads zero
    assign lab_we    = cmd.vis_mark || (cmd.scan_step && nb_reg[idx_reg]);
    assign lab_waddr = cmd.vis_mark ? a_reg : idx_reg;
    assign lab_wdata = cmd.vis_mark ? vis_label :
                       (first_reg ? ggvl_pkg::LBL_FIRST : ggvl_pkg::LBL_PLAIN);

    always_ff @(posedge aclk) begin
        if (lab_we) begin
            lab_mem[lab_waddr] <= lab_wdata;
        end
        if (cmd.lab_rd) begin
            lab_q_reg <= lab_mem[a_reg];
        end
        if (cmd.vis_mark) begin
            nb_reg <= nb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cmd.clr_mask) begin
            mask_reg <= '0;
        end else if (lab_we) begin
            mask_reg[lab_waddr] <= 1'b1;
        end
    end

    // neighbour scan, one slot a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end else if (cmd.vis_mark) begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + ggvl_pkg::vidx_t'(1);
            if (nb_reg[idx_reg]) begin
                first_reg <= 1'b0;
            end
        end
    end

    // result register
    assign out_is_lab = show && mask_reg[a_reg];
    assign out_label  = out_is_lab ? lab_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {4'b0000, bad, out_is_lab, out_label};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        st.add_ok     = is_add && a_ok && b_ok;
        st.visit_go   = is_visit && a_ok && !mask_reg[a_reg];
        st.clr_lab    = (req_reg == ggvl_pkg::REQ_CLR_LABELS);
        st.clr_graph  = (req_reg == ggvl_pkg::REQ_CLR_GRAPH);
        st.nb_pending = nb_any && nb_unl;
        st.scan_last  = (idx_reg == ggvl_pkg::vidx_t'(ggvl_pkg::MAX_VERTICES - 1));
        st.out_free   = !out_vld_reg || m_tready;
    end

endmodule

>>> rtl/ggvl_ctrl.sv
// ----------------------------------------------------------------------------
// ggvl_ctrl
// Controller: sequences row read-modify-writes, visits, the neighbour scan
// and the result hand-off.
// ----------------------------------------------------------------------------
module ggvl_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  ggvl_pkg::ggvl_status_t st,
    output ggvl_pkg::ggvl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_RD_B,
        ST_ADD_WR_B,
        ST_VIS_RD,
        ST_VIS_EVAL,
        ST_SCAN,
        ST_LAB_RD,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid && ready_reg;
                if (s_tvalid && ready_reg) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.clr_mask = st.clr_lab;
                cmd.clr_rows = st.clr_graph;
                if (st.add_ok) begin
                    state_next = ST_ADD_RD_A;
                end else if (st.visit_go) begin
                    state_next = ST_VIS_RD;
                end else begin
                    state_next = ST_LAB_RD;
                end
            end
            ST_ADD_RD_A: begin
                cmd.row_rd = 1'b1;
                state_next = ST_ADD_WR_A;
            end
            ST_ADD_WR_A: begin
                cmd.row_wr = 1'b1;
                state_next = ST_ADD_RD_B;
            end
            ST_ADD_RD_B: begin
                cmd.row_rd    = 1'b1;
                cmd.row_sel_b = 1'b1;
                state_next    = ST_ADD_WR_B;
            end
            ST_ADD_WR_B: begin
                cmd.row_wr    = 1'b1;
                cmd.row_sel_b = 1'b1;
                state_next    = ST_LAB_RD;
            end
            ST_VIS_RD: begin
                cmd.row_rd = 1'b1;
                state_next = ST_VIS_EVAL;
            end
            ST_VIS_EVAL: begin
                cmd.vis_mark = 1'b1;
                state_next   = st.nb_pending ? ST_SCAN : ST_LAB_RD;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.scan_last) begin
                    state_next = ST_LAB_RD;
                end
            end
            ST_LAB_RD: begin
                cmd.lab_rd = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // hold until the result register can take the answer
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

>>> rtl/greedy_graph_vertex_labeler.sv
// ----------------------------------------------------------------------------
// greedy_graph_vertex_labeler
// Greedy vertex labeler over an undirected adjacency bit matrix, with a
// stream request channel, a stream result channel and an APB register port.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   s_       | in        | s_tvalid/s_tready  | tuser req_type, tdata a, b
//   m_       | out       | m_tvalid/m_tready  | tdata label, is_labeled, bad
//   apb      | in        | psel/penable/ready | vertex_count at byte address 0
//
// One request at a time. An add edge does two read-modify-writes on the row
// memory; a visit that labels neighbours scans all 64 slots, one a cycle.
// Reset clears row valid bits and the labeled mask at once: no clearing pass.
// A result waits in the output register while the next request is taken; that
// request then holds in its final state until the register frees.
// ----------------------------------------------------------------------------
module greedy_graph_vertex_labeler (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] vertex_a, [11:6] vertex_b, [15:12] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] label, [2] is_labeled, [3] bad_index

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ggvl_pkg::ggvl_cmd_t          cmd;
    ggvl_pkg::ggvl_status_t       st;
    logic [ggvl_pkg::CNT_W-1:0]   vertex_count_reg;
    logic                         reg_sel;

    // register index is the word address
    assign reg_sel = (int'(paddr[2]) == ggvl_pkg::REG_VERTEX_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= ggvl_pkg::CNT_W'(ggvl_pkg::MAX_VERTICES);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            vertex_count_reg <= pwdata[ggvl_pkg::CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - ggvl_pkg::CNT_W){1'b0}}, vertex_count_reg} : 32'd0;

    ggvl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ggvl_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .s_req        (s_tuser),
        .s_a          (s_tdata[5:0]),
        .s_b          (s_tdata[11:6]),
        .vertex_count (vertex_count_reg),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tready     (m_tready)
    );

endmodule

>>> rtl/ggvl_checker.sv
// ----------------------------------------------------------------------------
// ggvl_checker
// Port-level checks for the greedy graph vertex labeler, bound to the top.
// ----------------------------------------------------------------------------
module ggvl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // leave reset ready for a request with no result pending
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("ggvl: wrong state after reset");

    // one request in flight: ready drops after each accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ggvl: request accepted while another is in flight");

    // a rejected index carries no label
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[2:0] == 3'd0))
        else $error("ggvl: bad index result carries a label");

    // an unlabeled vertex reads as label zero
    a_unlabeled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[1:0] == 2'd0))
        else $error("ggvl: unlabeled vertex shows a non-zero label");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("ggvl: stalled result changed");

endmodule

bind greedy_graph_vertex_labeler ggvl_checker u_ggvl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
